### design/dwr_pkg.sv
// shared types for the dual wheel pd drive ramp block
package dwr_pkg;

  localparam logic [3:0] REG_PROP_GAIN       = 4'd0;
  localparam logic [3:0] REG_DIFF_GAIN       = 4'd1;
  localparam logic [3:0] REG_SETTLE_BOOST    = 4'd2;
  localparam logic [3:0] REG_RAMP_LIMIT      = 4'd3;
  localparam logic [3:0] REG_SPEED_LIMIT     = 4'd4;
  localparam logic [3:0] REG_DISTANCE_WINDOW = 4'd5;
  localparam logic [3:0] REG_BEARING_WINDOW  = 4'd6;
  localparam logic [3:0] REG_TURN_MODE       = 4'd7;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] diff_gain;
    logic [14:0] settle_boost;
    logic [14:0] ramp_limit;
    logic [6:0]  speed_limit;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
    logic upd_err;
    logic upd_drive;
  } lane_ctrl_t;

endpackage

### design/dwr_lane.sv
// one wheel lane: error, pd drive, settle boost, ramp and speed clamp
module dwr_lane import dwr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctrl_t         ctrl,
  input  cfg_t               cfg,
  input  logic signed [31:0] target,
  input  logic signed [31:0] position,
  input  logic               settled,
  output logic               in_window,
  output logic signed [7:0]  power
);

  localparam logic signed [51:0] SAT_HI = 52'sd32512;
  localparam logic signed [51:0] SAT_LO = -52'sd32512;

  logic signed [32:0] err_wide;
  logic signed [31:0] err_sat;
  logic signed [31:0] err1;
  logic signed [31:0] err2;
  logic signed [31:0] last_err;
  logic signed [32:0] diff_w;
  logic signed [32:0] diff2;
  logic        [31:0] err_mag;
  logic               in2;
  logic               in3;
  logic signed [48:0] pp;
  logic signed [49:0] pd;
  logic signed [48:0] pp3;
  logic signed [49:0] pd3;
  logic signed [50:0] sum;
  logic signed [51:0] boosted;
  logic signed [15:0] goal;
  logic signed [15:0] goal4;
  logic signed [15:0] drive;
  logic signed [16:0] delta;
  logic signed [16:0] rlim;
  logic signed [16:0] step;
  logic signed [16:0] np;
  logic signed [16:0] slim;
  logic signed [16:0] np_c;
  logic signed [16:0] np_mag;
  logic        [7:0]  q;

  // stage 1: saturated error
  assign err_wide = {target[31], target} - {position[31], position};
  always_comb begin
    if (err_wide[32] != err_wide[31]) begin
      err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_sat = err_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      err1 <= err_sat;
    end
  end

  // stage 2: difference and window test
  assign diff_w  = {err1[31], err1} - {last_err[31], last_err};
  assign err_mag = err1[31] ? (~err1 + 32'd1) : err1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
    end else if (ctrl.upd_err) begin
      last_err <= err1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      err2  <= err1;
      diff2 <= diff_w;
      in2   <= err_mag < {16'd0, cfg.window};
    end
  end

  // stage 3: gain products
  assign pp = $signed({{17{err2[31]}}, err2}) * $signed({33'd0, cfg.prop_gain});
  assign pd = $signed({{17{diff2[32]}}, diff2}) * $signed({34'd0, cfg.diff_gain});

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      pp3 <= pp;
      pd3 <= pd;
      in3 <= in2;
    end
  end

  assign in_window = in3;

  // stage 4: sum, boost away from zero when settled, saturate
  assign sum = {{2{pp3[48]}}, pp3} + {pd3[49], pd3};

  always_comb begin
    if (settled && !sum[50] && (sum != '0)) begin
      boosted = {sum[50], sum} + {37'd0, cfg.settle_boost};
    end else if (settled && sum[50]) begin
      boosted = {sum[50], sum} - {37'd0, cfg.settle_boost};
    end else begin
      boosted = {sum[50], sum};
    end
    if (boosted > SAT_HI) begin
      goal = SAT_HI[15:0];
    end else if (boosted < SAT_LO) begin
      goal = SAT_LO[15:0];
    end else begin
      goal = boosted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      goal4 <= goal;
    end
  end

  // stage 5: ramp toward goal, clamp to speed limit
  assign delta = {goal4[15], goal4} - {drive[15], drive};
  assign rlim  = {2'b00, cfg.ramp_limit};
  assign slim  = {2'b00, cfg.speed_limit, 8'd0};

  always_comb begin
    if (delta > rlim) begin
      step = rlim;
    end else if (delta < -rlim) begin
      step = -rlim;
    end else begin
      step = delta;
    end
    np = {drive[15], drive} + step;
    if (np > slim) begin
      np_c = slim;
    end else if (np < -slim) begin
      np_c = -slim;
    end else begin
      np_c = np;
    end
    np_mag = np_c[16] ? -np_c : np_c;
    q      = np_mag[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
    end else if (ctrl.upd_drive) begin
      drive <= np_c[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en5) begin
      power <= np_c[16] ? -q : q;
    end
  end

endmodule

### design/dual_wheel_pd_drive_ramp.sv
// top level: config registers, pipeline control, two wheel lanes and settle merge
// Two identical lanes, one per wheel, run a five-stage pipeline: saturated
// error, error difference with window test, gain products, sum with settle
// boost and saturation, then ramp and speed clamp. The settle flags of both
// lanes are merged between the third and fourth stages. An enabled tick
// gives one result, and a new tick can be taken every cycle while the
// output is not stalled by m_tready; the ramp stage feeds its registered
// drive back into its next step. A tick with enable low is taken and gives
// no result. Configuration writes are taken every cycle.
module dual_wheel_pd_drive_ramp import dwr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_left, target_right, position_left, position_right
  input  logic [127:0] s_tdata,
  // enable
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // power_left, power_right
  output logic [15:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] prop_gain;
  logic [15:0] diff_gain;
  logic [14:0] settle_boost;
  logic [14:0] ramp_limit;
  logic [6:0]  speed_limit;
  logic [15:0] distance_window;
  logic [15:0] bearing_window;
  logic        turn_mode;

  cfg_t        cfg;
  lane_ctrl_t  ctrl;
  logic        v1, v2, v3, v4, v5;
  logic        take;
  logic        in_window_left, in_window_right;
  logic        settled;
  logic signed [7:0] power_left, power_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 16'd256;
      diff_gain       <= 16'd0;
      settle_boost    <= 15'd0;
      ramp_limit      <= 15'd2560;
      speed_limit     <= 7'd127;
      distance_window <= 16'd10;
      bearing_window  <= 16'd10;
      turn_mode       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:       prop_gain       <= cfg_data;
        REG_DIFF_GAIN:       diff_gain       <= cfg_data;
        REG_SETTLE_BOOST:    settle_boost    <= cfg_data[14:0];
        REG_RAMP_LIMIT:      ramp_limit      <= cfg_data[14:0];
        REG_SPEED_LIMIT:     speed_limit     <= cfg_data[6:0];
        REG_DISTANCE_WINDOW: distance_window <= cfg_data;
        REG_BEARING_WINDOW:  bearing_window  <= cfg_data;
        REG_TURN_MODE:       turn_mode       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.prop_gain    = prop_gain;
    cfg.diff_gain    = diff_gain;
    cfg.settle_boost = settle_boost;
    cfg.ramp_limit   = ramp_limit;
    cfg.speed_limit  = speed_limit;
    cfg.window       = turn_mode ? bearing_window : distance_window;
  end

  // pipeline advance, each stage moves when its successor frees up
  always_comb begin
    ctrl.en5       = !v5 || m_tready;
    ctrl.en4       = !v4 || ctrl.en5;
    ctrl.en3       = !v3 || ctrl.en4;
    ctrl.en2       = !v2 || ctrl.en3;
    ctrl.en1       = !v1 || ctrl.en2;
    ctrl.upd_err   = ctrl.en2 && v1;
    ctrl.upd_drive = ctrl.en5 && v4;
  end

  assign s_tready = ctrl.en1;
  assign take     = s_tvalid && ctrl.en1 && s_tuser[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ctrl.en1) v1 <= take;
      if (ctrl.en2) v2 <= v1;
      if (ctrl.en3) v3 <= v2;
      if (ctrl.en4) v4 <= v3;
      if (ctrl.en5) v5 <= v4;
    end
  end

  // both wheels must be inside the window
  assign settled = in_window_left && in_window_right;

  dwr_lane u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .target    (s_tdata[31:0]),
    .position  (s_tdata[95:64]),
    .settled   (settled),
    .in_window (in_window_left),
    .power     (power_left)
  );

  dwr_lane u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .target    (s_tdata[63:32]),
    .position  (s_tdata[127:96]),
    .settled   (settled),
    .in_window (in_window_right),
    .power     (power_right)
  );

  assign m_tvalid = v5;
  assign m_tdata  = {power_right, power_left};

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
    else $error("power outside symmetric range");

  a_disabled_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[0]) |=> !v1)
    else $error("disabled tick entered pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
